// ===== src/spdr_pkg.sv =====
package spdr_pkg;

	localparam int PKT_BYTES = 20;
	localparam int CNT_W     = 5;

	localparam logic [7:0] SYNC_BYTE  = 8'd19;
	localparam logic [7:0] LEN_BYTE   = 8'd17;
	localparam logic [7:0] ID_CLIFF_L  = 8'd28;
	localparam logic [7:0] ID_CLIFF_FL = 8'd29;
	localparam logic [7:0] ID_CLIFF_FR = 8'd30;
	localparam logic [7:0] ID_CLIFF_R  = 8'd31;
	localparam logic [7:0] ID_DIST     = 8'd19;
	localparam logic [7:0] ID_IR       = 8'd17;

	localparam logic [7:0] CMD_DRIVE_DIRECT = 8'd145;
	localparam logic [7:0] CMD_DIGITAL_OUTS = 8'd147;
	localparam logic [7:0] CMD_PLAY         = 8'd141;
	localparam logic [7:0] SONG_NUMBER      = 8'd0;

	localparam logic [8:0] MAX_SPEED = 9'd500;

	localparam int TX_MAX = 9;
	localparam int IDX_W  = 4;
	localparam logic [IDX_W-1:0] LAST_NO_SONG = 4'd6;
	localparam logic [IDX_W-1:0] LAST_SONG    = 4'd8;

	localparam logic [2:0] ACT_FORWARD  = 3'd0;
	localparam logic [2:0] ACT_LEFT     = 3'd1;
	localparam logic [2:0] ACT_RIGHT    = 3'd2;
	localparam logic [2:0] ACT_BACKWARD = 3'd3;
	localparam logic [2:0] ACT_STOP     = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_LIMIT        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRONT_LEFT_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRONT_RIGHT_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_LIMIT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POLARITY          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SPEED       = 3'd5;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [2:0] requested_action;
		logic       play_request;
	} item_t;

	typedef struct packed {
		logic [7:0]         tx_byte;
		logic               tx_last;
		logic [15:0]        cliff_left_raw;
		logic [15:0]        cliff_front_left_raw;
		logic [15:0]        cliff_front_right_raw;
		logic [15:0]        cliff_right_raw;
		logic [3:0]         cliff_bits;
		logic signed [15:0] distance_travelled;
		logic [7:0]         ir_code;
		logic [2:0]         drive_code;
		logic [31:0]        packet_number;
	} result_t;

	typedef struct packed {
		logic [15:0] cliff_left;
		logic [15:0] cliff_front_left;
		logic [15:0] cliff_front_right;
		logic [15:0] cliff_right;
		logic [15:0] distance;
		logic [7:0]  ir_code;
		logic [2:0]  action;
		logic        play;
		logic [31:0] number;
	} packet_t;

	typedef struct packed {
		logic [15:0] left_limit;
		logic [15:0] front_left_limit;
		logic [15:0] front_right_limit;
		logic [15:0] right_limit;
		logic        polarity;
		logic [8:0]  wheel_speed;
	} cfg_t;

endpackage

// ===== src/sensor_packet_deframer_with_reflex_top.sv =====
// Serial sensor deframer with cliff reflex. Takes one received byte per cycle into a
// 20-byte sliding window; the framing, sensor ids and checksum are checked as each
// byte lands, using a running window sum. An accepted packet is thresholded, the
// requested drive action is overridden to stop over a cliff edge, and 7 command
// beats (9 with a pending song request) leave one per ready cycle, all carrying the
// packet's sensor fields. Input stalls only while a second finished packet waits
// behind a run that has not yet drained; write the limit registers only when idle.
module sensor_packet_deframer_with_reflex_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  spdr_pkg::item_t                      item,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output spdr_pkg::result_t                    result,
	input  logic                                 cfg_wr_en,
	input  logic [spdr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [spdr_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import spdr_pkg::*;

	cfg_t    cfg_q;
	logic    pkt_valid;
	logic    pkt_take;
	packet_t pkt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_limit        <= 16'd0;
			cfg_q.front_left_limit  <= 16'd0;
			cfg_q.front_right_limit <= 16'd0;
			cfg_q.right_limit       <= 16'd0;
			cfg_q.polarity          <= 1'b1;
			cfg_q.wheel_speed       <= 9'd300;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LEFT_LIMIT:        cfg_q.left_limit        <= cfg_wdata;
				CFG_FRONT_LEFT_LIMIT:  cfg_q.front_left_limit  <= cfg_wdata;
				CFG_FRONT_RIGHT_LIMIT: cfg_q.front_right_limit <= cfg_wdata;
				CFG_RIGHT_LIMIT:       cfg_q.right_limit       <= cfg_wdata;
				CFG_POLARITY:          cfg_q.polarity          <= cfg_wdata[0];
				CFG_WHEEL_SPEED:       cfg_q.wheel_speed       <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	spdr_deframer u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.pkt_valid  (pkt_valid),
		.pkt_take   (pkt_take),
		.pkt        (pkt)
	);

	spdr_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pkt_valid    (pkt_valid),
		.pkt_take     (pkt_take),
		.pkt          (pkt),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== src/spdr_deframer.sv =====
module spdr_deframer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  spdr_pkg::item_t  item,
	output logic             pkt_valid,
	input  logic             pkt_take,
	output spdr_pkg::packet_t pkt
);
	import spdr_pkg::*;

	logic [7:0]       win_q [PKT_BYTES];
	logic [7:0]       nw    [PKT_BYTES];
	logic [7:0]       sum_q;
	logic [7:0]       sum_new;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      accepted_q;
	logic             play_pending_q;
	logic             pkt_valid_s1;
	packet_t          pkt_s1;
	logic             fire;
	logic             full;
	logic             ok;
	logic             accept_pkt;
	logic             play_now;

	assign item_ready = !pkt_valid_s1 || pkt_take;
	assign fire       = item_valid && item_ready;
	assign full       = (count_q == CNT_W'(PKT_BYTES - 1));
	assign play_now   = play_pending_q || item.play_request;

	// window as it stands once this beat has been shifted in
	always_comb begin
		for (int k = 0; k < PKT_BYTES - 1; k++) begin
			nw[k] = win_q[k+1];
		end
		nw[PKT_BYTES-1] = item.rx_byte;
	end

	// running sum of the whole window, kept in step with the shift
	assign sum_new = sum_q - win_q[0] + item.rx_byte;

	assign ok = (nw[0] == SYNC_BYTE) && (nw[1] == LEN_BYTE) &&
		(nw[2] == ID_CLIFF_L) && (nw[5] == ID_CLIFF_FL) &&
		(nw[8] == ID_CLIFF_FR) && (nw[11] == ID_CLIFF_R) &&
		(nw[14] == ID_DIST) && (nw[17] == ID_IR) && (sum_new == 8'd0);

	assign accept_pkt = fire && full && ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PKT_BYTES; k++) begin
				win_q[k] <= 8'd0;
			end
			sum_q          <= 8'd0;
			count_q        <= '0;
			accepted_q     <= '0;
			play_pending_q <= 1'b0;
			pkt_valid_s1   <= 1'b0;
		end else begin
			if (fire) begin
				for (int k = 0; k < PKT_BYTES; k++) begin
					win_q[k] <= nw[k];
				end
				sum_q <= sum_new;
				if (accept_pkt) begin
					count_q        <= '0;
					accepted_q     <= accepted_q + 32'd1;
					play_pending_q <= 1'b0;
				end else begin
					play_pending_q <= play_now;
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
			end
			if (accept_pkt) begin
				pkt_valid_s1 <= 1'b1;
			end else if (pkt_take) begin
				pkt_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_pkt) begin
			pkt_s1.cliff_left        <= {nw[3], nw[4]};
			pkt_s1.cliff_front_left  <= {nw[6], nw[7]};
			pkt_s1.cliff_front_right <= {nw[9], nw[10]};
			pkt_s1.cliff_right       <= {nw[12], nw[13]};
			pkt_s1.distance          <= {nw[15], nw[16]};
			pkt_s1.ir_code           <= nw[18];
			pkt_s1.action            <= item.requested_action;
			pkt_s1.play              <= play_now;
			pkt_s1.number            <= accepted_q;
		end
	end

	assign pkt_valid = pkt_valid_s1;
	assign pkt       = pkt_s1;

endmodule

// ===== src/spdr_emitter.sv =====
module spdr_emitter (
	input  logic              clk,
	input  logic              arst_n,
	input  spdr_pkg::cfg_t    cfg,
	input  logic              pkt_valid,
	output logic              pkt_take,
	input  spdr_pkg::packet_t pkt,
	output logic              result_valid,
	input  logic              result_ready,
	output spdr_pkg::result_t result
);
	import spdr_pkg::*;

	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last_idx_q;
	logic [7:0]       tx_q [TX_MAX];
	result_t          fields_q;
	logic             is_last;
	logic             fire;

	logic        bl, bfl, bfr, br, front;
	logic [2:0]  act_in;
	logic [2:0]  act;
	logic [8:0]  spd;
	logic [15:0] spd_pos;
	logic [15:0] spd_neg;
	logic [15:0] left_spd;
	logic [15:0] right_spd;

	assign is_last  = (idx_q == last_idx_q);
	assign fire     = busy_q && result_ready;
	assign pkt_take = pkt_valid && (!busy_q || (result_ready && is_last));

	// high reading gives the polarity bit, low reading its inverse
	assign bl  = ~((pkt.cliff_left > cfg.left_limit) ^ cfg.polarity);
	assign bfl = ~((pkt.cliff_front_left > cfg.front_left_limit) ^ cfg.polarity);
	assign bfr = ~((pkt.cliff_front_right > cfg.front_right_limit) ^ cfg.polarity);
	assign br  = ~((pkt.cliff_right > cfg.right_limit) ^ cfg.polarity);
	assign front = bfl | bfr;

	assign spd     = (cfg.wheel_speed > MAX_SPEED) ? MAX_SPEED : cfg.wheel_speed;
	assign spd_pos = {7'd0, spd};
	assign spd_neg = 16'd0 - spd_pos;

	always_comb begin
		act_in = (pkt.action > ACT_STOP) ? ACT_STOP : pkt.action;
		act    = act_in;
		// reflex: no driving over a cliff edge
		if ((act_in == ACT_FORWARD && front) || (act_in == ACT_BACKWARD && (bl | br))) begin
			act = ACT_STOP;
		end
		case (act)
			ACT_FORWARD: begin
				left_spd  = spd_pos;
				right_spd = spd_pos;
			end
			ACT_LEFT: begin
				left_spd  = spd_neg;
				right_spd = spd_pos;
			end
			ACT_RIGHT: begin
				left_spd  = spd_pos;
				right_spd = spd_neg;
			end
			ACT_BACKWARD: begin
				left_spd  = spd_neg;
				right_spd = spd_neg;
			end
			default: begin
				left_spd  = 16'd0;
				right_spd = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pkt_take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take) begin
			tx_q[0] <= CMD_DRIVE_DIRECT;
			tx_q[1] <= right_spd[15:8];
			tx_q[2] <= right_spd[7:0];
			tx_q[3] <= left_spd[15:8];
			tx_q[4] <= left_spd[7:0];
			tx_q[5] <= CMD_DIGITAL_OUTS;
			tx_q[6] <= {5'd0, bl, front, br};
			tx_q[7] <= CMD_PLAY;
			tx_q[8] <= SONG_NUMBER;
			last_idx_q <= pkt.play ? LAST_SONG : LAST_NO_SONG;
			fields_q.tx_byte               <= 8'd0;
			fields_q.tx_last               <= 1'b0;
			fields_q.cliff_left_raw        <= pkt.cliff_left;
			fields_q.cliff_front_left_raw  <= pkt.cliff_front_left;
			fields_q.cliff_front_right_raw <= pkt.cliff_front_right;
			fields_q.cliff_right_raw       <= pkt.cliff_right;
			fields_q.cliff_bits            <= {bl, bfl, bfr, br};
			fields_q.distance_travelled    <= signed'(pkt.distance);
			fields_q.ir_code               <= pkt.ir_code;
			fields_q.drive_code            <= act;
			fields_q.packet_number         <= pkt.number;
		end
	end

	always_comb begin
		result         = fields_q;
		result.tx_byte = tx_q[idx_q];
		result.tx_last = is_last;
	end

	assign result_valid = busy_q;

endmodule
